// ===== rtl/qvr_pkg.sv =====
// ============================================================================
// qvr_pkg
// Shared constant for the quaternion vector rotation block.
// ============================================================================
package qvr_pkg;

  // Default width of every quaternion, vector and result component
  localparam int unsigned DATA_WIDTH_DEF = 16;

endpackage

// ===== rtl/qvr_if.sv =====
// ============================================================================
// qvr_sample_if / qvr_result_if
// Valid/ready channels that carry one sample word and one result word.
// ============================================================================
interface qvr_sample_if #(
  parameter int unsigned DATA_WIDTH = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] quat_w;
  logic signed [DATA_WIDTH-1:0] quat_x;
  logic signed [DATA_WIDTH-1:0] quat_y;
  logic signed [DATA_WIDTH-1:0] quat_z;
  logic signed [DATA_WIDTH-1:0] vec_x;
  logic signed [DATA_WIDTH-1:0] vec_y;
  logic signed [DATA_WIDTH-1:0] vec_z;

  modport source (output valid, quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z,
                  input ready);
  modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z,
                  output ready);
endinterface

interface qvr_result_if #(
  parameter int unsigned DATA_WIDTH = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] rot_x;
  logic signed [DATA_WIDTH-1:0] rot_y;
  logic signed [DATA_WIDTH-1:0] rot_z;
  logic                         degenerate;

  modport source (output valid, rot_x, rot_y, rot_z, degenerate, input ready);
  modport sink   (input valid, rot_x, rot_y, rot_z, degenerate, output ready);
endinterface

// ===== rtl/quaternion_vector_rotate.sv =====
// ============================================================================
// quaternion_vector_rotate
// Rotates a vector by a quaternion (q v q*), normalizing q, fully pipelined.
// ============================================================================
// One sample word enters per cycle while the output is not stalled. The
// rotation is formed exactly as R(q) v / n with n = |q|^2, so no square
// root is taken and the fixed-point scale of the quaternion cancels. The
// restoring divider resolves one quotient bit per pipeline stage for each
// of the three components. Every stage advances together whenever the
// output register is empty or drained; a stalled result holds the whole
// pipeline. Components round half away from zero and saturate; a zero
// quaternion flags degenerate and returns zeros.
module quaternion_vector_rotate #(
  parameter int unsigned DATA_WIDTH = qvr_pkg::DATA_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  qvr_sample_if.sink   sample,
  qvr_result_if.source result
);
  import qvr_pkg::*;

  localparam int unsigned D     = DATA_WIDTH;
  localparam int unsigned PW    = 2*D;        // quaternion products
  localparam int unsigned MW    = 2*D + 2;    // rotation matrix entries
  localparam int unsigned NWID  = 2*D + 1;    // squared norm
  localparam int unsigned TW    = 3*D + 2;    // matrix times vector terms
  localparam int unsigned AW    = 3*D + 4;    // row sums
  localparam int unsigned NUMW  = 3*D + 5;    // 2|acc| + n
  localparam int unsigned DENW  = 2*D + 2;    // 2n
  localparam int unsigned QB    = D + 1;      // quotient bits resolved
  localparam int unsigned HIW   = NUMW - QB;

  logic adv;
  logic out_valid;

  // whole pipeline moves when the output register can take a word
  assign adv          = !out_valid || result.ready;
  assign sample.ready = adv;

  // stage 1: quaternion products
  logic                 v1;
  logic signed [PW-1:0] p_ww, p_xx, p_yy, p_zz, p_xy, p_wz, p_xz, p_wy, p_yz, p_wx;
  logic signed [D-1:0]  vec1 [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= sample.valid;
    end
    if (adv) begin
      p_ww    <= sample.quat_w * sample.quat_w;
      p_xx    <= sample.quat_x * sample.quat_x;
      p_yy    <= sample.quat_y * sample.quat_y;
      p_zz    <= sample.quat_z * sample.quat_z;
      p_xy    <= sample.quat_x * sample.quat_y;
      p_wz    <= sample.quat_w * sample.quat_z;
      p_xz    <= sample.quat_x * sample.quat_z;
      p_wy    <= sample.quat_w * sample.quat_y;
      p_yz    <= sample.quat_y * sample.quat_z;
      p_wx    <= sample.quat_w * sample.quat_x;
      vec1[0] <= sample.vec_x;
      vec1[1] <= sample.vec_y;
      vec1[2] <= sample.vec_z;
    end
  end

  // stage 2: integer rotation matrix and squared norm
  logic                 v2;
  logic signed [MW-1:0] m2 [3][3];
  logic [NWID-1:0]      n2;
  logic signed [D-1:0]  vec2 [3];
  logic signed [MW-1:0] nsum;

  assign nsum = MW'(p_ww) + MW'(p_xx) + MW'(p_yy) + MW'(p_zz);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
    if (adv) begin
      m2[0][0] <= MW'(p_ww) + MW'(p_xx) - MW'(p_yy) - MW'(p_zz);
      m2[0][1] <= (MW'(p_xy) - MW'(p_wz)) <<< 1;
      m2[0][2] <= (MW'(p_xz) + MW'(p_wy)) <<< 1;
      m2[1][0] <= (MW'(p_xy) + MW'(p_wz)) <<< 1;
      m2[1][1] <= MW'(p_ww) - MW'(p_xx) + MW'(p_yy) - MW'(p_zz);
      m2[1][2] <= (MW'(p_yz) - MW'(p_wx)) <<< 1;
      m2[2][0] <= (MW'(p_xz) - MW'(p_wy)) <<< 1;
      m2[2][1] <= (MW'(p_yz) + MW'(p_wx)) <<< 1;
      m2[2][2] <= MW'(p_ww) - MW'(p_xx) - MW'(p_yy) + MW'(p_zz);
      n2       <= nsum[NWID-1:0];
      vec2     <= vec1;
    end
  end

  // stage 3: matrix entry times vector component
  logic                 v3;
  logic signed [TW-1:0] t3 [3][3];
  logic [NWID-1:0]      n3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          t3[i][j] <= m2[i][j] * vec2[j];
        end
      end
      n3 <= n2;
    end
  end

  // stage 4: row sums
  logic                 v4;
  logic signed [AW-1:0] acc4 [3];
  logic [NWID-1:0]      n4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (adv) begin
      v4 <= v3;
    end
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        acc4[i] <= AW'(t3[i][0]) + AW'(t3[i][1]) + AW'(t3[i][2]);
      end
      n4 <= n3;
    end
  end

  // stage 5: magnitude, rounding numerator and divisor
  logic              v5;
  logic [NUMW-1:0]   num5 [3];
  logic              neg5 [3];
  logic [DENW-1:0]   den5;
  logic              deg5;
  logic [AW-1:0]     mag4 [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag4[i] = acc4[i][AW-1] ? AW'(-acc4[i]) : AW'(acc4[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (adv) begin
      v5 <= v4;
    end
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        num5[i] <= NUMW'({mag4[i], 1'b0}) + NUMW'(n4);
        neg5[i] <= acc4[i][AW-1];
      end
      den5 <= {n4, 1'b0};
      deg5 <= (n4 == '0);
    end
  end

  // divider pipeline: stage 0 checks the high part for overflow, then one
  // quotient bit per stage
  logic              dv   [QB+1];
  logic [DENW-1:0]   dden [QB+1];
  logic              ddeg [QB+1];
  logic [DENW-1:0]   drem [QB+1][3];
  logic [QB-1:0]     dlo  [QB+1][3];
  logic [QB-1:0]     dq   [QB+1][3];
  logic              dneg [QB+1][3];
  logic              dsat [QB+1][3];
  logic [HIW-1:0]    hi5  [3];
  logic              ovf5 [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      hi5[i]  = num5[i][NUMW-1:QB];
      ovf5[i] = (hi5[i] >= HIW'(den5));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (adv) begin
      dv[0] <= v5;
    end
    if (adv) begin
      dden[0] <= den5;
      ddeg[0] <= deg5;
      for (int i = 0; i < 3; i++) begin
        drem[0][i] <= ovf5[i] ? '0 : hi5[i][DENW-1:0];
        dlo[0][i]  <= num5[i][QB-1:0];
        dq[0][i]   <= '0;
        dneg[0][i] <= neg5[i];
        dsat[0][i] <= ovf5[i];
      end
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_div
    logic [DENW:0] shl [3];
    logic          ge  [3];

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        shl[i] = {drem[k][i], dlo[k][i][QB-1]};
        ge[i]  = (shl[i] >= {1'b0, dden[k]});
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[k+1] <= 1'b0;
      end else if (adv) begin
        dv[k+1] <= dv[k];
      end
      if (adv) begin
        dden[k+1] <= dden[k];
        ddeg[k+1] <= ddeg[k];
        for (int i = 0; i < 3; i++) begin
          drem[k+1][i] <= ge[i] ? DENW'(shl[i] - {1'b0, dden[k]}) : shl[i][DENW-1:0];
          dlo[k+1][i]  <= dlo[k][i] << 1;
          dq[k+1][i]   <= {dq[k][i][QB-2:0], ge[i]};
          dneg[k+1][i] <= dneg[k][i];
          dsat[k+1][i] <= dsat[k][i];
        end
      end
    end
  end

  // output register: clamp, restore sign, degenerate override
  logic [QB-1:0]       lim  [3];
  logic [QB-1:0]       qs   [3];
  logic signed [D-1:0] rot_next [3];
  logic signed [D-1:0] rot  [3];
  logic                deg_out;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lim[i] = dneg[QB][i] ? (QB'(1) << (D-1)) : ((QB'(1) << (D-1)) - QB'(1));
      qs[i]  = (dsat[QB][i] || (dq[QB][i] > lim[i])) ? lim[i] : dq[QB][i];
      if (ddeg[QB]) begin
        rot_next[i] = '0;
      end else if (dneg[QB][i]) begin
        rot_next[i] = D'(-qs[i]);
      end else begin
        rot_next[i] = D'(qs[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= dv[QB];
    end
    if (adv) begin
      rot     <= rot_next;
      deg_out <= ddeg[QB];
    end
  end

  assign result.valid      = out_valid;
  assign result.rot_x      = rot[0];
  assign result.rot_y      = rot[1];
  assign result.rot_z      = rot[2];
  assign result.degenerate = deg_out;

endmodule

// ===== rtl/qvr_check.sv =====
// ============================================================================
// qvr_check
// Port-level checks for the quaternion vector rotation block.
// ============================================================================
module qvr_check #(
  parameter int unsigned DATA_WIDTH = qvr_pkg::DATA_WIDTH_DEF
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [DATA_WIDTH-1:0] rot_x,
  input logic [DATA_WIDTH-1:0] rot_y,
  input logic [DATA_WIDTH-1:0] rot_z,
  input logic                  degenerate
);
  import qvr_pkg::*;

  // a stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(rot_x) && $stable(rot_y)
      && $stable(rot_z) && $stable(degenerate))
    else $error("result word changed while stalled");

  // degenerate result carries zeros
  a_deg_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> rot_x == '0 && rot_y == '0 && rot_z == '0)
    else $error("degenerate result not zero");

  // empty output register never blocks the input
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  // a stalled output holds the input side
  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken during output stall");

  // result valid is low when reset deasserts
  a_no_early: assert property (@(posedge clk)
    $fell(rst) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind quaternion_vector_rotate qvr_check #(.DATA_WIDTH(DATA_WIDTH)) u_qvr_check (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (sample.ready),
  .out_valid  (result.valid),
  .out_ready  (result.ready),
  .rot_x      (result.rot_x),
  .rot_y      (result.rot_y),
  .rot_z      (result.rot_z),
  .degenerate (result.degenerate)
);

// ===== dv/qvr_rotation_checker.sv =====
// ============================================================================
// qvr_rotation_checker
// Watches both channels, predicts each rotated vector and compares it.
// ============================================================================
// The rotation is computed exactly as R(q) v / n with n = |q|^2, rounded half
// away from zero and saturated to the component width.
`timescale 1ns / 1ps

module qvr_rotation_checker #(
  parameter int unsigned DATA_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  qvr_sample_if       sample,
  qvr_result_if       result,
  output int unsigned errors,
  output int unsigned pending
);

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] rot_x;
    logic signed [DATA_WIDTH-1:0] rot_y;
    logic signed [DATA_WIDTH-1:0] rot_z;
    logic                         degenerate;
  } rot_word_t;

  rot_word_t rot_queue[$];

  // Round |acc|/n half away from zero, then clamp to the signed range
  function automatic logic signed [DATA_WIDTH-1:0] scale_round(
    input logic signed [127:0] acc, input logic signed [127:0] n);
    logic signed [127:0] mag;
    logic signed [127:0] quo;
    logic signed [127:0] lim;
    logic                neg;
    neg = acc < 0;
    mag = neg ? -acc : acc;
    quo = (2 * mag + n) / (2 * n);
    lim = (128'sd1 <<< (DATA_WIDTH - 1)) - (neg ? 0 : 1);
    if (quo > lim) quo = lim;
    return neg ? -quo : quo;
  endfunction

  function automatic rot_word_t rotate_vector(
    input logic signed [DATA_WIDTH-1:0] qw, qx, qy, qz, vx, vy, vz);
    logic signed [127:0] w, x, y, z, a, b, c, n, ax, ay, az;
    rot_word_t r;
    w = qw; x = qx; y = qy; z = qz; a = vx; b = vy; c = vz;
    n = w*w + x*x + y*y + z*z;
    r = '0;
    if (n == 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    ax = (w*w + x*x - y*y - z*z)*a + 2*(x*y - w*z)*b + 2*(x*z + w*y)*c;
    ay = 2*(x*y + w*z)*a + (w*w - x*x + y*y - z*z)*b + 2*(y*z - w*x)*c;
    az = 2*(x*z - w*y)*a + 2*(y*z + w*x)*b + (w*w - x*x - y*y + z*z)*c;
    r.rot_x = scale_round(ax, n);
    r.rot_y = scale_round(ay, n);
    r.rot_z = scale_round(az, n);
    return r;
  endfunction

  assign pending = rot_queue.size();

  // Predict on accepted samples, compare on accepted results
  always @(posedge clk) begin
    rot_word_t   exp_w;
    int unsigned n_err;
    n_err = 0;
    if (rst) begin
      errors <= 0;
    end else begin
      if (sample.valid && sample.ready)
        rot_queue.push_back(rotate_vector(sample.quat_w, sample.quat_x, sample.quat_y,
          sample.quat_z, sample.vec_x, sample.vec_y, sample.vec_z));
      if (result.valid && result.ready) begin
        if (rot_queue.size() == 0) begin
          $error("unexpected result word");
          n_err++;
        end else begin
          exp_w = rot_queue.pop_front();
          if (exp_w.rot_x !== result.rot_x) begin
            $error("rot_x: expected %0d, actual %0d", exp_w.rot_x, result.rot_x);
            n_err++;
          end
          if (exp_w.rot_y !== result.rot_y) begin
            $error("rot_y: expected %0d, actual %0d", exp_w.rot_y, result.rot_y);
            n_err++;
          end
          if (exp_w.rot_z !== result.rot_z) begin
            $error("rot_z: expected %0d, actual %0d", exp_w.rot_z, result.rot_z);
            n_err++;
          end
          if (exp_w.degenerate !== result.degenerate) begin
            $error("degenerate: expected %0d, actual %0d", exp_w.degenerate,
                   result.degenerate);
            n_err++;
          end
        end
      end
      errors <= errors + n_err;
    end
  end

endmodule

// ===== dv/quaternion_vector_rotate_tb.sv =====
// ============================================================================
// quaternion_vector_rotate_tb
// Stimulus and verdict for the quaternion vector rotation block.
// ============================================================================
// Directed corners (zero, extreme and unit quaternions, extreme vectors), then
// random words with random gaps and stalls, a run with no idling and one long output hold-off.
`timescale 1ns / 1ps

module quaternion_vector_rotate_tb;

  localparam int unsigned DW        = qvr_pkg::DATA_WIDTH_DEF;
  localparam int          N_RANDOM  = 700;
  localparam int          IDLE_PCT  = 19;
  localparam int          WDOG_MAX  = 5000;
  localparam int          DRAIN_CYC = 64;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic stall_free = 1'b0;
  logic hold_off = 1'b0;
  int unsigned errors, pending;
  int idle_cnt;

  qvr_sample_if #(.DATA_WIDTH(DW)) sample ();
  qvr_result_if #(.DATA_WIDTH(DW)) result ();

  quaternion_vector_rotate #(.DATA_WIDTH(DW)) dut (
    .clk(clk), .rst(rst), .sample(sample), .result(result));

  qvr_rotation_checker #(.DATA_WIDTH(DW)) u_checker (
    .clk(clk), .rst(rst), .sample(sample), .result(result),
    .errors(errors), .pending(pending));

  always #5 clk = ~clk;

  // Random quaternion component: half within +/-16384, a quarter within -128..127, a quarter anything
  function automatic logic [DW-1:0] rand_quat();
    case ($urandom_range(0, 3))
      0:       return DW'($urandom());
      1:       return DW'($urandom_range(0, 255) - 128);
      default: return DW'($urandom_range(0, 32768) - 16384);
    endcase
  endfunction

  // Offer one sample word and hold it until accepted; valid drops only on idle
  task automatic send_word(input logic [DW-1:0] qw, qx, qy, qz, vx, vy, vz);
    while (!stall_free && $urandom_range(0, 99) < IDLE_PCT) begin
      sample.valid <= 1'b0;
      @(negedge clk);
    end
    sample.valid  <= 1'b1;
    sample.quat_w <= qw; sample.quat_x <= qx; sample.quat_y <= qy;
    sample.quat_z <= qz; sample.vec_x  <= vx; sample.vec_y  <= vy;
    sample.vec_z  <= vz;
    @(posedge clk);
    while (!sample.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Output side: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_off) result.ready <= 1'b0;
    else result.ready <= stall_free || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Watchdog on cycles without any accepted word
  always @(posedge clk) begin
    if (rst || (sample.valid && sample.ready) || (result.valid && result.ready))
      idle_cnt <= 0;
    else begin
      idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= WDOG_MAX) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    logic [DW-1:0] ext[4];
    ext = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};
    sample.valid = 1'b0;
    {sample.quat_w, sample.quat_x, sample.quat_y, sample.quat_z} = '0;
    {sample.vec_x, sample.vec_y, sample.vec_z} = '0;
    result.ready = 1'b0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // Directed corners
    send_word(0, 0, 0, 0, 16'h1234, 16'h8000, 16'h7FFF);
    send_word(16384, 0, 0, 0, 16'h8000, 16'h7FFF, 16'h0001);
    send_word(0, 16384, 0, 0, 100, DW'(-200), 300);
    send_word(0, 0, 16384, 0, 100, DW'(-200), 300);
    send_word(0, 0, 0, 16384, 100, DW'(-200), 300);
    send_word(11585, 11585, 0, 0, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_word(11585, 0, 0, 11585, 16'h8000, 16'h8000, 16'h8000);
    send_word(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
    send_word(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
    send_word(1, 1, 1, 0, 1, 0, 0);
    send_word(8192, 8192, 8192, 8192, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_word(0, 0, 0, 0, 0, 0, 0);
    send_word(0, 1, 0, 0, 1, 1, 0);
    for (int i = 0; i < 8; i++)
      send_word(ext[i % 4], ext[(i + 1) % 4], ext[(i + 2) % 4], ext[(i + 3) % 4],
                ext[i % 4], ext[(i + 3) % 4], ext[(i + 1) % 4]);

    // Random words; a run with no idling, then a long output hold-off
    for (int i = 0; i < N_RANDOM; i++) begin
      stall_free <= (i >= 200 && i < 300);
      if (i == 400) begin
        fork
          begin
            hold_off <= 1'b1;
            repeat (150) @(negedge clk);
            hold_off <= 1'b0;
          end
        join_none
      end
      if ($urandom_range(0, 49) == 0)
        send_word(0, 0, 0, 0, DW'($urandom()), DW'($urandom()), DW'($urandom()));
      else
        send_word(rand_quat(), rand_quat(), rand_quat(), rand_quat(),
                  DW'($urandom()), DW'($urandom()), DW'($urandom()));
    end
    sample.valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYC) @(negedge clk);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
